>>> rtl/core/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal engine.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned Vertices = 4096;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AddrW    = $clog2(Vertices);
  localparam int unsigned CoordW   = 32;
  localparam int unsigned VertW    = 3 * CoordW;

  localparam logic KindVertex = 1'b0;
  localparam logic KindFace   = 1'b1;
  localparam logic TypeNormal = 1'b0;
  localparam logic TypeVertex = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [11:0]        vertex_slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [11:0]        index_a;
    logic [11:0]        index_b;
    logic [11:0]        index_c;
  } in_item_t;

  typedef struct packed {
    logic               item_type;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
    logic               last;
  } out_item_t;

endpackage

>>> rtl/core/tfn_ram.sv
// ----------------------------------------------------------------------------
// tfn_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tfn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/triangle_face_normal_engine_core.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_engine_core
// Stores vertices and emits unit face normals plus scaled face vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i. A vertex transaction
//   writes one table entry. A face transaction reads three entries,
//   scales, forms the cross product and normalizes it with a bit-serial
//   square root (32 steps) and three restoring divisions (48 steps each),
//   all on the one shared iterative unit. The time a face takes depends
//   on how many one-bit shifts bring the cross product into range; a
//   degenerate face skips the square root and the divisions.
//   Output channel out_valid_o/out_stall_i/out_data_o: four transactions
//   per face, normal first, then vertices A, B, C (last set on C).
//   One item is in work at a time; the next is accepted once the four
//   results have been taken. A stalled output holds its payload.
//   Reset clears all control state; the vertex table is undefined until
//   written, so faces must only name written entries.
// ----------------------------------------------------------------------------
module triangle_face_normal_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tfn_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tfn_pkg::out_item_t  out_data_o
);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StRead  = 12'b000000000010,
    StScale = 12'b000000000100,
    StEdge  = 12'b000000001000,
    StMul   = 12'b000000010000,
    StCross = 12'b000000100000,
    StNorm  = 12'b000001000000,
    StSq    = 12'b000010000000,
    StSqrt  = 12'b000100000000,
    StDiv   = 12'b001000000000,
    StEmit  = 12'b010000000000,
    StWrite = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic                         ram_we;
  logic [tfn_pkg::AddrW-1:0]    ram_addr;
  logic [tfn_pkg::VertW-1:0]    ram_rdata;

  tfn_pkg::in_item_t            item_q;
  logic [1:0]                   cnt_q;     // vertex read / emit / div index
  logic [1:0]                   rcv_q;     // read data capture index
  logic                         rd_pend_q;
  logic signed [31:0]           sv_q [3][3];
  logic signed [32:0]           e1_q [3];
  logic signed [32:0]           e2_q [3];
  logic signed [63:0]           pr_q [6];
  logic [65:0]                  mag_q [3];
  logic [2:0]                   neg_q;
  logic                         degen_q;
  logic [63:0]                  sum_q;
  logic [63:0]                  rem_q;
  logic [63:0]                  res_q;
  logic [5:0]                   step_q;
  logic [31:0]                  len_q;
  logic [47:0]                  dvd_q;
  logic [31:0]                  quo_q [3];
  logic                         out_valid_q;
  tfn_pkg::out_item_t           out_q;

  tfn_ram #(.Width(tfn_pkg::VertW), .Depth(tfn_pkg::Vertices)) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i({item_q.coord_x, item_q.coord_y, item_q.coord_z}),
    .rdata_o(ram_rdata)
  );

  // table port: write in StWrite, read the vertex named by cnt_q in StRead
  always_comb begin
    ram_we   = (state_q == StWrite);
    ram_addr = item_q.vertex_slot;
    if (state_q == StRead) begin
      case (cnt_q)
        2'd0:    ram_addr = item_q.index_a;
        2'd1:    ram_addr = item_q.index_b;
        default: ram_addr = item_q.index_c;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // scaling helpers
  function automatic logic signed [31:0] scale_down(logic signed [31:0] v);
    logic [31:0] m;
    logic [63:0] p;
    logic [31:0] q;
    m = v[31] ? 32'(-v) : 32'(v);
    p = 64'(m) * 64'd3435973837;     // ceil(2^36/20)
    q = 32'(p[63:36]);
    return v[31] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] scale_up(logic signed [31:0] v);
    logic signed [33:0] p;
    p = 34'(v) * 34'sd3;
    if (p > 34'sd2147483647) return 32'sh7fffffff;
    if (p < -34'sd2147483648) return 32'sh80000000;
    return p[31:0];
  endfunction

  logic [5:0]  lead;
  logic [65:0] mmax;
  logic        wide;
  logic [63:0] trial;

  // largest magnitude and its leading one position, wide-edge flag and square-root trial value
  always_comb begin
    mmax = mag_q[0];
    if (mag_q[1] > mmax) mmax = mag_q[1];
    if (mag_q[2] > mmax) mmax = mag_q[2];
    lead = '0;
    for (int k = 0; k < 64; k++) begin
      if (mmax[k]) lead = 6'(k);
    end
    wide = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (e1_q[j][32] != e1_q[j][31] || e2_q[j][32] != e2_q[j][31]) wide = 1'b1;
    end
    trial = {res_q[61:0], 2'b01};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = in_data_i.kind ? StRead : StWrite;
      StWrite: state_d = StIdle;
      StRead:  if (rcv_q == 2'd2 && rd_pend_q) state_d = StScale;
      StScale: state_d = StEdge;
      StEdge:  state_d = StMul;
      StMul:   state_d = StCross;
      StCross: state_d = StNorm;
      StNorm: begin
        // zero cross product skips straight to the results
        if (mmax == '0) state_d = StEmit;
        else if (mmax[65:30] == '0 && mmax[29]) state_d = StSq;
      end
      StSq:    state_d = StSqrt;
      StSqrt:  if (step_q == 6'd31) state_d = StDiv;
      StDiv:   if (step_q == 6'd47 && cnt_q == 2'd2) state_d = StEmit;
      StEmit:  if (!out_valid_q || !out_stall_i) begin
        if (cnt_q == 2'd0 && out_valid_q && out_q.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rcv_q       <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // load the next result, else drop a taken one
      if (state_q == StEmit && (!out_valid_q || !out_stall_i) &&
          !(cnt_q == 2'd0 && out_valid_q && out_q.last)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          cnt_q     <= '0;
          rcv_q     <= '0;
          rd_pend_q <= 1'b0;
        end
        StRead: begin
          // issue reads, capture each read's data in the cycle after
          if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
          rd_pend_q <= 1'b1;
          if (rd_pend_q) rcv_q <= rcv_q + 2'd1;
        end
        StDiv: begin
          if (step_q == 6'd47) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
        end
        StEmit: begin
          if (!out_valid_q || !out_stall_i) begin
            if (!(cnt_q == 2'd0 && out_valid_q && out_q.last)) begin
              cnt_q <= cnt_q + 2'd1;
            end
          end
        end
        default: cnt_q <= (state_d == StDiv || state_d == StEmit) ? 2'd0 : cnt_q;
      endcase
    end
  end

  // datapath, payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    unique case (state_q)
      StRead: begin
        if (rd_pend_q) begin
          sv_q[rcv_q][0] <= ram_rdata[95:64];
          sv_q[rcv_q][1] <= ram_rdata[63:32];
          sv_q[rcv_q][2] <= ram_rdata[31:0];
        end
      end
      StScale: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (sv_q[0][0] >= 32'sd655360) sv_q[i][j] <= scale_down(sv_q[i][j]);
            else sv_q[i][j] <= scale_up(sv_q[i][j]);
          end
        end
      end
      StEdge: begin
        for (int j = 0; j < 3; j++) begin
          e1_q[j] <= 33'(sv_q[0][j]) - 33'(sv_q[1][j]);
          e2_q[j] <= 33'(sv_q[0][j]) - 33'(sv_q[2][j]);
        end
      end
      StMul: begin
        // halve toward zero when any edge is wide, then multiply
        logic signed [32:0] a [3];
        logic signed [32:0] b [3];
        for (int j = 0; j < 3; j++) begin
          a[j] = wide ? $signed(e1_q[j] + 33'(e1_q[j][32])) >>> 1 : e1_q[j];
          b[j] = wide ? $signed(e2_q[j] + 33'(e2_q[j][32])) >>> 1 : e2_q[j];
        end
        pr_q[0] <= 64'(a[1]) * 64'(b[2]);
        pr_q[1] <= 64'(a[2]) * 64'(b[1]);
        pr_q[2] <= 64'(b[0]) * 64'(a[2]);
        pr_q[3] <= 64'(b[2]) * 64'(a[0]);
        pr_q[4] <= 64'(b[1]) * 64'(a[0]);
        pr_q[5] <= 64'(b[0]) * 64'(a[1]);
      end
      StCross: begin
        for (int j = 0; j < 3; j++) begin
          logic signed [65:0] c;
          c = (j == 0) ? 66'(pr_q[0]) - 66'(pr_q[1]) :
              (j == 1) ? 66'(pr_q[2]) - 66'(pr_q[3]) : 66'(pr_q[4]) - 66'(pr_q[5]);
          neg_q[j] <= c[65];
          mag_q[j] <= c[65] ? 66'(-c) : 66'(c);
        end
      end
      StNorm: begin
        degen_q <= (mmax == '0);
        // shift toward [2^29, 2^30) one bit a cycle
        if (mmax != '0) begin
          if (lead > 6'd29 || mmax[65:64] != 2'b00) begin
            for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
          end else if (lead < 6'd29) begin
            for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] << 1;
          end
        end
      end
      StSq: begin
        sum_q  <= 64'(mag_q[0][29:0]) * 64'(mag_q[0][29:0]) +
                  64'(mag_q[1][29:0]) * 64'(mag_q[1][29:0]) +
                  64'(mag_q[2][29:0]) * 64'(mag_q[2][29:0]);
        rem_q  <= '0;
        res_q  <= '0;
        step_q <= '0;
      end
      StSqrt: begin
        // one result bit per cycle
        logic [63:0] r;
        r = {rem_q[61:0], sum_q[63:62]};
        sum_q <= {sum_q[61:0], 2'b00};
        res_q <= {res_q[62:0], (r >= trial)};
        if (step_q == 6'd31) begin
          len_q  <= (r >= trial) ? {res_q[30:0], 1'b1} : {res_q[30:0], 1'b0};
          step_q <= '0;
          rem_q  <= '0;
          dvd_q  <= {mag_q[0][31:0], 16'd0};
        end else begin
          rem_q  <= (r >= trial) ? r - trial : r;
          step_q <= step_q + 6'd1;
        end
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle
        logic [32:0] r;
        r = {rem_q[31:0], dvd_q[47]};
        if (step_q == 6'd47) begin
          quo_q[cnt_q] <= {dvd_q[30:0], (r >= 33'(len_q))};
          step_q <= '0;
          rem_q  <= '0;
          dvd_q  <= {(cnt_q == 2'd0) ? mag_q[1][31:0] : mag_q[2][31:0], 16'd0};
        end else begin
          dvd_q  <= {dvd_q[46:0], (r >= 33'(len_q))};
          rem_q  <= (r >= 33'(len_q)) ? 64'(r - 33'(len_q)) : 64'(r);
          step_q <= step_q + 6'd1;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          unique case (cnt_q)
            2'd0: begin
              out_q.item_type  <= tfn_pkg::TypeNormal;
              out_q.degenerate <= degen_q;
              out_q.last       <= 1'b0;
              out_q.out_x <= degen_q ? '0 : (neg_q[0] ? -$signed(quo_q[0]) : $signed(quo_q[0]));
              out_q.out_y <= degen_q ? '0 : (neg_q[1] ? -$signed(quo_q[1]) : $signed(quo_q[1]));
              out_q.out_z <= degen_q ? '0 : (neg_q[2] ? -$signed(quo_q[2]) : $signed(quo_q[2]));
            end
            default: begin
              out_q.item_type  <= tfn_pkg::TypeVertex;
              out_q.degenerate <= 1'b0;
              out_q.out_x <= sv_q[cnt_q - 2'd1][0];
              out_q.out_y <= sv_q[cnt_q - 2'd1][1];
              out_q.out_z <= sv_q[cnt_q - 2'd1][2];
              out_q.last  <= (cnt_q == 2'd3);
            end
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

>>> verif/triangle_face_normal_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_engine_core_tb
// Drives vertex writes and face requests into the engine and checks every
// normal and scaled vertex against a fixed-point predictor kept here.
// ----------------------------------------------------------------------------

class face_result_board;
  tfn_pkg::out_item_t pending_q[$];
  logic [95:0] shadow_tbl [0:4095];
  int errors;

  function new();
    errors = 0;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Note an accepted input transaction and queue the results it causes.
  function void note_input(tfn_pkg::in_item_t it);
    logic signed [63:0] sv [3][3];
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] cr [3];
    logic signed [63:0] nrm [3];
    logic [63:0] mag [3];
    logic [63:0] m, sum, len, q;
    logic [11:0] idx [3];
    logic wide;
    logic degen;
    tfn_pkg::out_item_t r;
    if (it.kind == tfn_pkg::KindVertex) begin
      shadow_tbl[it.vertex_slot] = {it.coord_x, it.coord_y, it.coord_z};
      return;
    end
    idx[0] = it.index_a;
    idx[1] = it.index_b;
    idx[2] = it.index_c;
    for (int i = 0; i < 3; i++) begin
      sv[i][0] = $signed(shadow_tbl[idx[i]][95:64]);
      sv[i][1] = $signed(shadow_tbl[idx[i]][63:32]);
      sv[i][2] = $signed(shadow_tbl[idx[i]][31:0]);
    end
    // Scale all nine coordinates together
    if (sv[0][0] >= (64'sd10 <<< tfn_pkg::FracBits)) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) sv[i][j] = sv[i][j] / 20;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) sv[i][j] = clamp32(sv[i][j] * 3);
    end
    wide = 1'b0;
    for (int j = 0; j < 3; j++) begin
      e1[j] = sv[0][j] - sv[1][j];
      e2[j] = sv[0][j] - sv[2][j];
      if (clamp32(e1[j]) != e1[j] || clamp32(e2[j]) != e2[j]) wide = 1'b1;
    end
    if (wide)
      for (int j = 0; j < 3; j++) begin
        e1[j] = e1[j] / 2;
        e2[j] = e2[j] / 2;
      end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e2[0] * e1[2] - e2[2] * e1[0];
    cr[2] = e2[1] * e1[0] - e2[0] * e1[1];
    m = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = cr[j] < 0 ? 64'd0 - cr[j] : cr[j];
      if (mag[j] > m) m = mag[j];
    end
    degen = (m == 0);
    if (degen) begin
      for (int j = 0; j < 3; j++) nrm[j] = 0;
    end else begin
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int j = 0; j < 3; j++) mag[j] = mag[j] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int j = 0; j < 3; j++) mag[j] = mag[j] << 1;
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = floor_sqrt(sum);
      for (int j = 0; j < 3; j++) begin
        q = (mag[j] << tfn_pkg::FracBits) / len;
        nrm[j] = cr[j] < 0 ? -$signed(q) : $signed(q);
      end
    end
    r = '0;
    r.item_type = tfn_pkg::TypeNormal;
    r.out_x = nrm[0][31:0];
    r.out_y = nrm[1][31:0];
    r.out_z = nrm[2][31:0];
    r.degenerate = degen;
    pending_q.insert(pending_q.size(), r);
    for (int i = 0; i < 3; i++) begin
      r = '0;
      r.item_type = tfn_pkg::TypeVertex;
      r.out_x = sv[i][0][31:0];
      r.out_y = sv[i][1][31:0];
      r.out_z = sv[i][2][31:0];
      r.last = (i == 2);
      pending_q.insert(pending_q.size(), r);
    end
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Check one output transaction against the oldest expectation.
  task check_result(tfn_pkg::out_item_t got);
    tfn_pkg::out_item_t want;
    if (pending_q.size() == 0) begin
      report("unexpected result", got.out_x, 0);
      return;
    end
    want = pending_q.pop_front();
    if (got.item_type !== want.item_type) report("item_type", got.item_type, want.item_type);
    if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
    if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
    if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
    if (got.degenerate !== want.degenerate)
      report("degenerate", got.degenerate, want.degenerate);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask
endclass

module triangle_face_normal_engine_core_tb;

  localparam int WatchLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  tfn_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  tfn_pkg::out_item_t out_data_o;

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles = 0;
  logic written [0:4095];
  int written_slots[$];
  face_result_board board;

  triangle_face_normal_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sample both channels and keep the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Randomly stall the result channel
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Idle first, then hold the transaction until it is accepted
  task automatic send(tfn_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (it.kind == tfn_pkg::KindVertex) begin
      if (!written[it.vertex_slot]) written_slots.insert(written_slots.size(), it.vertex_slot);
      written[it.vertex_slot] = 1'b1;
    end
  endtask

  task automatic put_vertex(logic [11:0] slot, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    tfn_pkg::in_item_t it;
    it = tfn_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = tfn_pkg::KindVertex;
    it.vertex_slot = slot;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send(it);
  endtask

  task automatic put_face(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    tfn_pkg::in_item_t it;
    it = tfn_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = tfn_pkg::KindFace;
    it.index_a = a;
    it.index_b = b;
    it.index_c = c;
    send(it);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h7FFF_FFFF, 32'h7FF0_0000) ^ {1'($urandom_range(1)), 31'd0};
      2: return 32'(int'($urandom_range(40 << 16)) - (20 << 16));
      default: return 32'(int'($urandom_range(4000)) - 2000) << 10;
    endcase
  endfunction

  function automatic logic [11:0] any_written();
    return 12'(written_slots[$urandom_range(written_slots.size() - 1)]);
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if (written_slots.size() < 3 || $urandom_range(2) == 0)
        put_vertex($urandom_range(4095), pick_coord(), pick_coord(), pick_coord());
      else
        put_face(any_written(), any_written(), any_written());
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 4096; i++) written[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, scaling branches, degenerate and wide edges
    send_idle_pct = 18;
    recv_idle_pct = 54;
    put_vertex(12'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    put_vertex(12'd1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    put_vertex(12'd2, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    put_vertex(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    put_vertex(12'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    put_vertex(12'd4, 32'h000A_0000, 32'h0005_0000, 32'hFFFF_0000);
    put_vertex(12'd5, 32'h0009_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    put_vertex(12'd6, 32'h2AAA_AAAB, 32'hD555_5555, 32'h0000_0000);
    put_vertex(12'd2048, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_face(12'd0, 12'd1, 12'd2);
    put_face(12'd2, 12'd1, 12'd0);
    put_face(12'd0, 12'd0, 12'd0);
    put_face(12'd1, 12'd1, 12'd2);
    put_face(12'd4095, 12'd3, 12'd0);
    put_face(12'd3, 12'd4095, 12'd2048);
    put_face(12'd4, 12'd5, 12'd1);
    put_face(12'd5, 12'd4, 12'd6);
    put_face(12'd6, 12'd3, 12'd4095);
    put_face(12'd2048, 12'd6, 12'd4);

    random_phase(60);
    // Hold off until every expected result has come
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    send_idle_pct = 54;
    recv_idle_pct = 18;
    random_phase(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(70);

    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/tfn_pkg.sv
rtl/core/tfn_ram.sv
rtl/core/triangle_face_normal_engine_core.sv
verif/triangle_face_normal_engine_core_tb.sv
